@@ design/lfu_pkg.sv @@
// ============================================================================
// lfu_pkg
// Shared types and constants for the LFU cache with LRU tie-break.
// ============================================================================
package lfu_pkg;

  localparam int unsigned ENTRIES_DEF    = 16;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CFG_W   = 5;

  localparam logic [CFG_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RESOLVE,
    ST_SCAN,
    ST_WRITE
  } lfu_state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TOUCH,
    CELL_REPLACE,
    CELL_INSERT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     write_value;
  } cell_ctl_t;

endpackage

@@ design/lfu_cell.sv @@
// ============================================================================
// lfu_cell
// One cache entry: key match, use count and recency update, and one stage of
// the victim / free-slot chain passed on to the next cell every cycle.
// ============================================================================
module lfu_cell #(
  parameter int unsigned ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
  parameter int unsigned IDX        = 0,
  localparam int unsigned IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lfu_pkg::cell_ctl_t          ctl,
  input  logic signed [31:0]          req_key,
  input  logic signed [31:0]          req_value,
  input  logic [IDX_W-1:0]            ref_rank,
  input  logic [IDX_W-1:0]            target_idx,
  input  logic                        prev_vfound,
  input  logic [COUNT_BITS-1:0]       prev_vcount,
  input  logic [IDX_W-1:0]            prev_vrank,
  input  logic [IDX_W-1:0]            prev_vidx,
  input  logic                        prev_ffound,
  input  logic [IDX_W-1:0]            prev_fidx,
  output logic                        vfound,
  output logic [COUNT_BITS-1:0]       vcount,
  output logic [IDX_W-1:0]            vrank,
  output logic [IDX_W-1:0]            vidx,
  output logic                        ffound,
  output logic [IDX_W-1:0]            fidx,
  output logic                        match,
  output logic [IDX_W-1:0]            hit_rank,
  output logic signed [31:0]          hit_value
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic                    valid_r, valid_nxt;
  logic signed [31:0]      key_r, key_nxt;
  logic signed [31:0]      value_r, value_nxt;
  logic [COUNT_BITS-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]        rank_r, rank_nxt;
  logic                    match_r, match_nxt;

  logic                    vfound_r, vfound_nxt;
  logic [COUNT_BITS-1:0]   vcount_r, vcount_nxt;
  logic [IDX_W-1:0]        vrank_r, vrank_nxt;
  logic [IDX_W-1:0]        vidx_r, vidx_nxt;
  logic                    ffound_r, ffound_nxt;
  logic [IDX_W-1:0]        fidx_r, fidx_nxt;

  logic                    own_better;
  logic                    is_target;

  assign is_target = (target_idx == MY_IDX);
  assign match_nxt = valid_r && (key_r == req_key);

  // entry update
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    count_nxt = count_r;
    rank_nxt  = rank_r;
    unique case (ctl.op)
      lfu_pkg::CELL_HOLD: begin
      end
      lfu_pkg::CELL_TOUCH: begin
        if (match_r) begin
          rank_nxt = '0;
          if (count_r != '1) begin
            count_nxt = count_r + COUNT_BITS'(1);
          end
          if (ctl.write_value) begin
            value_nxt = req_value;
          end
        end else if (valid_r && (rank_r < ref_rank)) begin
          rank_nxt = rank_r + IDX_W'(1);
        end
      end
      lfu_pkg::CELL_REPLACE,
      lfu_pkg::CELL_INSERT: begin
        if (is_target) begin
          valid_nxt = 1'b1;
          key_nxt   = req_key;
          value_nxt = req_value;
          count_nxt = COUNT_BITS'(1);
          rank_nxt  = '0;
        end else if (valid_r &&
                     ((ctl.op == lfu_pkg::CELL_INSERT) || (rank_r < ref_rank))) begin
          rank_nxt = rank_r + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // chain stage: lowest count, then oldest; and a free slot
  assign own_better = !prev_vfound ||
                      (count_r < prev_vcount) ||
                      ((count_r == prev_vcount) && (rank_r > prev_vrank));

  always_comb begin
    if (valid_r && own_better) begin
      vfound_nxt = 1'b1;
      vcount_nxt = count_r;
      vrank_nxt  = rank_r;
      vidx_nxt   = MY_IDX;
    end else begin
      vfound_nxt = prev_vfound;
      vcount_nxt = prev_vcount;
      vrank_nxt  = prev_vrank;
      vidx_nxt   = prev_vidx;
    end
    if (!valid_r && !prev_ffound) begin
      ffound_nxt = 1'b1;
      fidx_nxt   = MY_IDX;
    end else begin
      ffound_nxt = prev_ffound;
      fidx_nxt   = prev_fidx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      match_r  <= 1'b0;
      vfound_r <= 1'b0;
      ffound_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      match_r  <= match_nxt;
      vfound_r <= vfound_nxt;
      ffound_r <= ffound_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    value_r  <= value_nxt;
    count_r  <= count_nxt;
    rank_r   <= rank_nxt;
    vcount_r <= vcount_nxt;
    vrank_r  <= vrank_nxt;
    vidx_r   <= vidx_nxt;
    fidx_r   <= fidx_nxt;
  end

  assign vfound    = vfound_r;
  assign vcount    = vcount_r;
  assign vrank     = vrank_r;
  assign vidx      = vidx_r;
  assign ffound    = ffound_r;
  assign fidx      = fidx_r;
  assign match     = match_r;
  assign hit_rank  = match_r ? rank_r : '0;
  assign hit_value = match_r ? value_r : '0;

endmodule

@@ design/lfu_cache.sv @@
// ============================================================================
// lfu_cache
// Key-value cache, least-frequently-used replacement, LRU among equal counts.
// ----------------------------------------------------------------------------
// Request: pulse start with in_action (0 get, 1 put), in_key, in_value while
// busy is low. busy rises the cycle after and stays high until the result.
// Result: out_valid is high for exactly one cycle with out_hit,
// out_read_value (stored value on a get hit, -1 otherwise) and out_evicted.
// The receiver cannot stall; busy drops in the cycle the result shows, so a
// new request can be issued in that same cycle.
// States after accept: a hit, a get miss or a put at zero capacity pass match
// and resolve; a put that misses adds the victim search (scan), which moves
// one cell per cycle along the row, and then write.
// Configuration: cfg_capacity_in_use is written on cfg_valid & cfg_ready
// (ready while idle). Values above ENTRIES act as ENTRIES; 0 stores nothing.
// Reset (rst_n low, synchronous) empties the cache and sets the capacity to
// 16. No clearing pass is needed.
// ============================================================================
module lfu_cache #(
  parameter int unsigned ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_action,
  input  logic signed [31:0]       in_key,
  input  logic signed [31:0]       in_value,
  output logic                     out_valid,
  output logic                     out_hit,
  output logic signed [31:0]       out_read_value,
  output logic                     out_evicted,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [lfu_pkg::CFG_W-1:0] cfg_capacity_in_use
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam int unsigned CAP_W = (OCC_W > lfu_pkg::CFG_W) ? OCC_W : lfu_pkg::CFG_W;

  lfu_pkg::lfu_state_t state_r, state_nxt;

  logic                       req_put_r;
  logic signed [31:0]         req_key_r;
  logic signed [31:0]         req_value_r;
  logic [lfu_pkg::CFG_W-1:0]  capacity_r;
  logic [OCC_W-1:0]           occ_r, occ_nxt;
  logic [IDX_W-1:0]           scan_cnt_r, scan_cnt_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_hit_r, out_hit_nxt;
  logic signed [31:0]         out_read_value_r, out_read_value_nxt;
  logic                       out_evicted_r, out_evicted_nxt;

  lfu_pkg::cell_ctl_t         cell_ctl;
  logic [IDX_W-1:0]           ref_rank;
  logic [IDX_W-1:0]           target_idx;

  logic [ENTRIES-1:0]         c_vfound;
  logic [COUNT_BITS-1:0]      c_vcount [ENTRIES];
  logic [IDX_W-1:0]           c_vrank  [ENTRIES];
  logic [IDX_W-1:0]           c_vidx   [ENTRIES];
  logic [ENTRIES-1:0]         c_ffound;
  logic [IDX_W-1:0]           c_fidx   [ENTRIES];
  logic [ENTRIES-1:0]         c_match;
  logic [IDX_W-1:0]           c_hit_rank  [ENTRIES];
  logic signed [31:0]         c_hit_value [ENTRIES];

  logic [IDX_W-1:0]           hit_rank;
  logic signed [31:0]         hit_value;
  logic                       any_hit;
  logic [CAP_W-1:0]           cap_eff;
  logic                       cap_zero;
  logic                       full;
  logic                       accept;

  assign accept    = start && !busy;
  assign busy      = (state_r != lfu_pkg::ST_IDLE);
  assign cfg_ready = !busy;

  always_comb begin
    cap_eff = (CAP_W'(capacity_r) > CAP_W'(ENTRIES)) ? CAP_W'(ENTRIES) : CAP_W'(capacity_r);
  end
  assign cap_zero = (cap_eff == '0);
  assign full     = (CAP_W'(occ_r) >= cap_eff);

  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_rank  = hit_rank | c_hit_rank[i];
      hit_value = hit_value | c_hit_value[i];
    end
  end
  assign any_hit = |c_match;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lfu_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = lfu_pkg::ST_MATCH;
        end
      end
      lfu_pkg::ST_MATCH: begin
        state_nxt = lfu_pkg::ST_RESOLVE;
      end
      lfu_pkg::ST_RESOLVE: begin
        if (!any_hit && req_put_r && !cap_zero) begin
          state_nxt = lfu_pkg::ST_SCAN;
        end else begin
          state_nxt = lfu_pkg::ST_IDLE;
        end
      end
      lfu_pkg::ST_SCAN: begin
        if (scan_cnt_r == '0) begin
          state_nxt = lfu_pkg::ST_WRITE;
        end
      end
      lfu_pkg::ST_WRITE: begin
        state_nxt = lfu_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lfu_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs and cell commands
  always_comb begin
    cell_ctl.op          = lfu_pkg::CELL_HOLD;
    cell_ctl.write_value = req_put_r;
    ref_rank             = hit_rank;
    target_idx           = c_fidx[ENTRIES-1];
    occ_nxt              = occ_r;
    scan_cnt_nxt         = scan_cnt_r;
    out_valid_nxt        = 1'b0;
    out_hit_nxt          = out_hit_r;
    out_read_value_nxt   = out_read_value_r;
    out_evicted_nxt      = out_evicted_r;
    unique case (state_r)
      lfu_pkg::ST_IDLE: begin
      end
      lfu_pkg::ST_MATCH: begin
        scan_cnt_nxt = IDX_W'(ENTRIES - 1);
      end
      lfu_pkg::ST_RESOLVE: begin
        if (any_hit) begin
          cell_ctl.op = lfu_pkg::CELL_TOUCH;
        end
        if (any_hit || !req_put_r || cap_zero) begin
          out_valid_nxt      = 1'b1;
          out_hit_nxt        = any_hit;
          out_read_value_nxt = (any_hit && (req_put_r == lfu_pkg::ACT_GET)) ?
                               hit_value : lfu_pkg::MISS_VALUE;
          out_evicted_nxt    = 1'b0;
        end
      end
      lfu_pkg::ST_SCAN: begin
        scan_cnt_nxt = scan_cnt_r - IDX_W'(1);
      end
      lfu_pkg::ST_WRITE: begin
        out_valid_nxt      = 1'b1;
        out_hit_nxt        = 1'b0;
        out_read_value_nxt = lfu_pkg::MISS_VALUE;
        if (full) begin
          cell_ctl.op     = lfu_pkg::CELL_REPLACE;
          ref_rank        = c_vrank[ENTRIES-1];
          target_idx      = c_vidx[ENTRIES-1];
          out_evicted_nxt = 1'b1;
        end else begin
          cell_ctl.op     = lfu_pkg::CELL_INSERT;
          occ_nxt         = occ_r + OCC_W'(1);
          out_evicted_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfu_pkg::ST_IDLE;
      occ_r       <= '0;
      scan_cnt_r  <= '0;
      capacity_r  <= lfu_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_capacity_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r        <= out_hit_nxt;
    out_read_value_r <= out_read_value_nxt;
    out_evicted_r    <= out_evicted_nxt;
    if (accept) begin
      req_put_r   <= in_action;
      req_key_r   <= in_key;
      req_value_r <= in_value;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_read_value_r;
  assign out_evicted    = out_evicted_r;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic                  p_vfound;
    logic [COUNT_BITS-1:0] p_vcount;
    logic [IDX_W-1:0]      p_vrank;
    logic [IDX_W-1:0]      p_vidx;
    logic                  p_ffound;
    logic [IDX_W-1:0]      p_fidx;

    if (g == 0) begin : g_head
      assign p_vfound = 1'b0;
      assign p_vcount = '0;
      assign p_vrank  = '0;
      assign p_vidx   = '0;
      assign p_ffound = 1'b0;
      assign p_fidx   = '0;
    end else begin : g_link
      assign p_vfound = c_vfound[g-1];
      assign p_vcount = c_vcount[g-1];
      assign p_vrank  = c_vrank[g-1];
      assign p_vidx   = c_vidx[g-1];
      assign p_ffound = c_ffound[g-1];
      assign p_fidx   = c_fidx[g-1];
    end

    lfu_cell #(
      .ENTRIES    (ENTRIES),
      .COUNT_BITS (COUNT_BITS),
      .IDX        (g)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (cell_ctl),
      .req_key     (req_key_r),
      .req_value   (req_value_r),
      .ref_rank    (ref_rank),
      .target_idx  (target_idx),
      .prev_vfound (p_vfound),
      .prev_vcount (p_vcount),
      .prev_vrank  (p_vrank),
      .prev_vidx   (p_vidx),
      .prev_ffound (p_ffound),
      .prev_fidx   (p_fidx),
      .vfound      (c_vfound[g]),
      .vcount      (c_vcount[g]),
      .vrank       (c_vrank[g]),
      .vidx        (c_vidx[g]),
      .ffound      (c_ffound[g]),
      .fidx        (c_fidx[g]),
      .match       (c_match[g]),
      .hit_rank    (c_hit_rank[g]),
      .hit_value   (c_hit_value[g])
    );
  end

endmodule
